// ===== rtl/core/mvsf_pkg.sv =====
package mvsf_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_DATA_SIZE      = 3'd0;
   localparam logic [2:0] CSR_SIGNED_COMPARE = 3'd1;
   localparam logic [2:0] CSR_COMPARE_FUNC   = 3'd2;
   localparam logic [2:0] CSR_COMPARE_PREV   = 3'd3;
   localparam logic [2:0] CSR_COMPARE_VALUE  = 3'd4;
   localparam logic [2:0] CSR_BIG_ENDIAN     = 3'd5;
   localparam logic [2:0] CSR_REGION_LENGTH  = 3'd6;

   // Relation codes
   localparam logic [2:0] FUNC_LT = 3'd0;
   localparam logic [2:0] FUNC_GT = 3'd1;
   localparam logic [2:0] FUNC_LE = 3'd2;
   localparam logic [2:0] FUNC_GE = 3'd3;
   localparam logic [2:0] FUNC_EQ = 3'd4;
   localparam logic [2:0] FUNC_NE = 3'd5;

   // Item kinds
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_TEST    = 1'b1;

   // Register reset values
   localparam logic [2:0]  RST_DATA_SIZE     = 3'd1;
   localparam logic [2:0]  RST_COMPARE_FUNC  = FUNC_EQ;
   localparam logic [16:0] RST_REGION_LENGTH = 17'h10000;

   // Sign fill masks, indexed by byte count minus one
   localparam logic [31:0] SIGN_FILL [4] = '{
      32'hFFFF_FF80, 32'hFFFF_8000, 32'hFF80_0000, 32'h8000_0000
   };
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // Queue depths
   localparam int MID_DEPTH   = 2;
   localparam int OUT_DEPTH   = 2;
   localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  data_size;
      logic        signed_compare;
      logic [2:0]  compare_func;
      logic        compare_to_previous;
      logic [31:0] compare_value;
      logic        big_endian;
      logic [16:0] region_length;
   } cfg_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic        kind;
      logic [15:0] position;
      logic        keep;
   } cmd_type;

   typedef struct packed {
      logic [15:0] echo_position;
      logic        still_shown;
      logic [16:0] survivor_count;
   } rsp_type;

endpackage

// ===== rtl/core/memory_value_scan_filter.sv =====
// Survivor filter for repeated value scans over a memory region.
// Input side is a queue: present an item and raise push; it is taken at a
// clock edge where push is high and full is low. A restart item (kind 0)
// marks every position below region_length and the store size as a survivor;
// a test item (kind 1) brings the current and snapshot bytes at one position.
// Result side is a queue: while empty is low the oldest result is on the
// rsp_ ports and is taken at an edge where pop is high. Exactly one result
// per item, in order.
// An item is taken only while the back end is idle and its result has a
// slot waiting. A test item in range reads its bitmap word as it is taken
// and writes it back in the modify state; the next item waits for it.
// A restart rewrites the whole bitmap, one 32-bit word per cycle; test items
// keep queueing meanwhile. Reset clears the registers to their defaults and
// runs a clearing pass over the bitmap with full held high. A stalled result
// side fills the two-entry result queue, then the two-entry item queue,
// after which full rises; nothing is lost. csr_ writes take effect at once;
// the user must make them only while the block is idle; it is not enforced.
module memory_value_scan_filter
   import mvsf_pkg::*;
#(
   parameter int REGION_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [15:0] req_position,
   input  logic [31:0] req_current_bytes,
   input  logic [31:0] req_previous_bytes,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_echo_position,
   output logic        rsp_still_shown,
   output logic [16:0] rsp_survivor_count,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cfg_type                cfg_ff;
   cmd_type                front_cmd;
   logic [CMD_W-1:0]       mid_data;
   logic                   mid_full;
   logic                   mid_empty;
   logic                   cmd_pop;
   logic                   back_clearing;
   logic                   rsp_push;
   rsp_type                back_rsp;
   logic [RSP_W-1:0]       out_data;
   logic                   out_full;
   logic [OUT_LEVEL_W-1:0] out_level;
   rsp_type                out_rsp;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_size           <= RST_DATA_SIZE;
         cfg_ff.signed_compare      <= 1'b0;
         cfg_ff.compare_func        <= RST_COMPARE_FUNC;
         cfg_ff.compare_to_previous <= 1'b0;
         cfg_ff.compare_value       <= '0;
         cfg_ff.big_endian          <= 1'b0;
         cfg_ff.region_length       <= RST_REGION_LENGTH;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DATA_SIZE:      cfg_ff.data_size           <= csr_wdata[2:0];
            CSR_SIGNED_COMPARE: cfg_ff.signed_compare      <= csr_wdata[0];
            CSR_COMPARE_FUNC:   cfg_ff.compare_func        <= csr_wdata[2:0];
            CSR_COMPARE_PREV:   cfg_ff.compare_to_previous <= csr_wdata[0];
            CSR_COMPARE_VALUE:  cfg_ff.compare_value       <= csr_wdata;
            CSR_BIG_ENDIAN:     cfg_ff.big_endian          <= csr_wdata[0];
            CSR_REGION_LENGTH:  cfg_ff.region_length       <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Hold off input while the item queue is full or the bitmap is clearing
   assign full = mid_full || back_clearing;

   // Front: assemble values and decide the relation
   mvsf_front u_front (
      .cfg            (cfg_ff),
      .kind           (req_kind),
      .position       (req_position),
      .current_bytes  (req_current_bytes),
      .previous_bytes (req_previous_bytes),
      .cmd            (front_cmd)
   );

   mvsf_queue #(
      .WIDTH (CMD_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push && !full),
      .push_data (front_cmd),
      .full      (mid_full),
      .pop       (cmd_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty),
      .level     ()
   );

   // Back: survivor bitmap, sweeps and count
   mvsf_back #(
      .REGION_BYTES (REGION_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .region_length (cfg_ff.region_length),
      .cmd_valid     (!mid_empty),
      .cmd           (cmd_type'(mid_data)),
      .cmd_pop       (cmd_pop),
      .out_level     (out_level),
      .rsp_push      (rsp_push),
      .rsp           (back_rsp),
      .clearing      (back_clearing)
   );

   mvsf_queue #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_data),
      .empty     (empty),
      .level     (out_level)
   );

   assign out_rsp            = rsp_type'(out_data);
   assign rsp_echo_position  = out_rsp.echo_position;
   assign rsp_still_shown    = out_rsp.still_shown;
   assign rsp_survivor_count = out_rsp.survivor_count;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !out_full)
      else $error("result pushed into a full queue");
   a_full_on_clear: assert property (@(posedge clock) disable iff (reset)
      back_clearing |-> full)
      else $error("input open during clearing pass");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result vanished");
`endif

endmodule

// ===== rtl/core/mvsf_queue.sv =====
module mvsf_queue
   import mvsf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   output logic                           full,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     level
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [LW-1:0]    level_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (level_ff == LW'(DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign pop_data = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(DEPTH))
      else $error("queue level beyond depth");
   a_level_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> level_ff == LW'($past(level_ff) + 1'b1))
      else $error("queue level did not rise on push");
   a_level_down: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> level_ff == LW'($past(level_ff) - 1'b1))
      else $error("queue level did not fall on pop");
`endif

endmodule

// ===== rtl/core/mvsf_front.sv =====
module mvsf_front
   import mvsf_pkg::*;
(
   input  cfg_type     cfg,
   input  logic        kind,
   input  logic [15:0] position,
   input  logic [31:0] current_bytes,
   input  logic [31:0] previous_bytes,
   output cmd_type     cmd
);

   logic [1:0]  size_sel;
   logic [31:0] cur_value;
   logic [31:0] prev_value;
   logic [31:0] opnd_a;
   logic [31:0] opnd_b;
   logic [31:0] sign_flip;
   logic        keep;

   // Assemble a value of sel+1 bytes, first byte in 7:0 of the input
   function automatic logic [31:0] assemble(input logic [31:0] b, input logic [1:0] sel,
                                            input logic be, input logic sgn);
      logic [31:0] v;
      logic [31:0] fill;
      fill = SIGN_FILL[sel];
      if (be) begin
         unique case (sel)
            2'd0: v = {24'd0, b[7:0]};
            2'd1: v = {16'd0, b[7:0], b[15:8]};
            2'd2: v = {8'd0, b[7:0], b[15:8], b[23:16]};
            2'd3: v = {b[7:0], b[15:8], b[23:16], b[31:24]};
         endcase
      end else begin
         unique case (sel)
            2'd0: v = {24'd0, b[7:0]};
            2'd1: v = {16'd0, b[15:0]};
            2'd2: v = {8'd0, b[23:0]};
            2'd3: v = b;
         endcase
      end
      if (sgn && ((v & fill) != '0)) begin
         v = v | fill;
      end
      return v;
   endfunction

   // Clamp the byte count: zero acts as one, above four acts as four
   always_comb begin
      unique case (cfg.data_size)
         3'd0, 3'd1: size_sel = 2'd0;
         3'd2:       size_sel = 2'd1;
         3'd3:       size_sel = 2'd2;
         default:    size_sel = 2'd3;
      endcase
   end

   assign cur_value  = assemble(current_bytes, size_sel, cfg.big_endian, cfg.signed_compare);
   assign prev_value = assemble(previous_bytes, size_sel, cfg.big_endian, cfg.signed_compare);

   // Bias both operands so one unsigned compare serves signed mode too
   assign sign_flip = {cfg.signed_compare, 31'd0};
   assign opnd_a    = cur_value ^ sign_flip;
   assign opnd_b    = (cfg.compare_to_previous ? prev_value : cfg.compare_value) ^ sign_flip;

   // Evaluate the relation; unused codes keep every survivor
   always_comb begin
      case (cfg.compare_func)
         FUNC_LT: keep = opnd_a < opnd_b;
         FUNC_GT: keep = opnd_a > opnd_b;
         FUNC_LE: keep = opnd_a <= opnd_b;
         FUNC_GE: keep = opnd_a >= opnd_b;
         FUNC_EQ: keep = opnd_a == opnd_b;
         FUNC_NE: keep = opnd_a != opnd_b;
         default: keep = 1'b1;
      endcase
   end

   assign cmd.kind     = kind;
   assign cmd.position = position;
   assign cmd.keep     = keep;

endmodule

// ===== rtl/core/mvsf_back.sv =====
module mvsf_back
   import mvsf_pkg::*;
#(
   parameter int REGION_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [16:0]            region_length,
   input  logic                   cmd_valid,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   input  logic [OUT_LEVEL_W-1:0] out_level,
   output logic                   rsp_push,
   output rsp_type                rsp,
   output logic                   clearing
);

   localparam int          WORDS        = (REGION_BYTES + 31) / 32;
   localparam int          AW           = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [31:0] REGION_LIMIT = 32'(REGION_BYTES);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MODIFY
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] idx_ff;
   logic [16:0]   len_ff;
   logic [16:0]   count_ff;
   logic          emit_ff;
   logic [15:0]   pos_ff;
   logic [AW-1:0] word_ff;
   logic          keep_ff;
   logic          rsp_push_ff;
   rsp_type       rsp_ff;

   logic [31:0]   bitmap_mem [WORDS];
   logic [31:0]   rdata_ff;

   logic [16:0]          eff_len;
   logic [31:0]          pos32;
   logic                 cmd_in_range;
   logic [AW-1:0]        cmd_word;
   logic [OUT_LEVEL_W:0] out_claim;
   logic                 out_room;
   logic                 take;
   logic [31:0]          sweep_full;
   logic [31:0]          idx32;
   logic [31:0]          sweep_word;
   logic                 cur_bit;
   logic                 drop;
   logic [31:0]          cleared_word;
   logic [16:0]          dec_count;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [31:0]          mem_wdata;
   logic                 mem_re;

   // Clip the region to the store
   assign eff_len = (32'(region_length) > REGION_LIMIT) ? 17'(REGION_BYTES) : region_length;

   // Locate the tested position
   assign pos32        = 32'(cmd.position);
   assign cmd_in_range = pos32 < REGION_LIMIT;
   assign cmd_word     = pos32[5 +: AW];

   // Start an item only when its result has a slot waiting
   assign out_claim = (OUT_LEVEL_W + 1)'(out_level) + (OUT_LEVEL_W + 1)'(rsp_push_ff);
   assign out_room  = out_claim < (OUT_LEVEL_W + 1)'(OUT_DEPTH);
   assign take      = (state_ff == ST_IDLE) && cmd_valid && out_room;
   assign cmd_pop   = take;
   assign clearing  = (state_ff == ST_SWEEP) && !emit_ff;

   // Word pattern for the sweep: full words, one partial word, then zeros
   assign sweep_full = 32'(len_ff[16:5]);
   assign idx32      = 32'(idx_ff);
   assign sweep_word = (idx32 < sweep_full) ? ALL_ONES :
                       (idx32 == sweep_full) ? ~(ALL_ONES << len_ff[4:0]) : '0;

   // Read-modify-write of one survivor bit
   assign cur_bit      = rdata_ff[pos_ff[4:0]];
   assign drop         = cur_bit && !keep_ff;
   assign cleared_word = rdata_ff & ~(32'd1 << pos_ff[4:0]);
   assign dec_count    = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   assign mem_re    = take && (cmd.kind == KIND_TEST) && cmd_in_range;
   assign mem_we    = (state_ff == ST_SWEEP) || ((state_ff == ST_MODIFY) && drop);
   assign mem_waddr = (state_ff == ST_SWEEP) ? idx_ff : word_ff;
   assign mem_wdata = (state_ff == ST_SWEEP) ? sweep_word : cleared_word;

   // Bitmap store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= bitmap_mem[cmd_word];
      end
   end

   // Sequencer: sweep, take an item, apply the test
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_SWEEP;
         idx_ff      <= '0;
         len_ff      <= '0;
         count_ff    <= '0;
         emit_ff     <= 1'b0;
         rsp_push_ff <= 1'b0;
         pos_ff      <= '0;
         word_ff     <= '0;
         keep_ff     <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         rsp_push_ff <= 1'b0;
         unique case (state_ff)
            ST_SWEEP: begin
               if (idx_ff == AW'(WORDS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
                  if (emit_ff) begin
                     rsp_push_ff <= 1'b1;
                     rsp_ff      <= '{echo_position: '0, still_shown: |len_ff,
                                      survivor_count: len_ff};
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (take) begin
                  if (cmd.kind == KIND_RESTART) begin
                     len_ff   <= eff_len;
                     count_ff <= eff_len;
                     idx_ff   <= '0;
                     emit_ff  <= 1'b1;
                     state_ff <= ST_SWEEP;
                  end else if (cmd_in_range) begin
                     pos_ff   <= cmd.position;
                     word_ff  <= cmd_word;
                     keep_ff  <= cmd.keep;
                     state_ff <= ST_MODIFY;
                  end else begin
                     rsp_push_ff <= 1'b1;
                     rsp_ff      <= '{echo_position: cmd.position, still_shown: 1'b0,
                                      survivor_count: count_ff};
                  end
               end
            end
            ST_MODIFY: begin
               rsp_push_ff <= 1'b1;
               state_ff    <= ST_IDLE;
               if (drop) begin
                  count_ff <= dec_count;
                  rsp_ff   <= '{echo_position: pos_ff, still_shown: 1'b0,
                                survivor_count: dec_count};
               end else begin
                  rsp_ff   <= '{echo_position: pos_ff, still_shown: cur_bit,
                                survivor_count: count_ff};
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_push = rsp_push_ff;
   assign rsp      = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= len_ff)
      else $error("survivor count above region length");
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SWEEP || state_ff == ST_MODIFY))
      else $error("bitmap written outside sweep or update");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !cmd_pop)
      else $error("item taken during clearing pass");
   a_modify_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> $past(mem_re))
      else $error("update without a preceding bitmap read");
`endif

endmodule

// ===== test/memory_value_scan_filter_tb.sv =====
`timescale 1ns / 1ps

module memory_value_scan_filter_tb;
   import mvsf_pkg::*;

   localparam int REGION_BYTES    = 65536;
   localparam int SETTLE_CYCLES   = REGION_BYTES / 32 + 64;
   localparam int LIMIT_CYCLES    = 2_000_000;
   localparam int PHASES          = 16;
   localparam int BEATS_PER_PHASE = 30;
   localparam int HOLD_OFF_CYCLES = REGION_BYTES / 32 + 1000;

   // relation codes the block treats as keep-all
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   // register settings per phase
   localparam int FLAVOR_RANDOM    = 0;
   localparam int FLAVOR_ALL_ONES  = 1;
   localparam int FLAVOR_ALL_ZEROS = 2;

   typedef struct packed {
      logic        kind;
      logic [15:0] position;
      logic [31:0] current_bytes;
      logic [31:0] previous_bytes;
   } scan_beat_type;

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_op_type;

   typedef struct {
      row_op_type    op;
      logic [2:0]    reg_index;
      logic [31:0]   reg_value;
      scan_beat_type beat;
      bit            typed;
      rsp_type       want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_kind = 1'b0;
   logic [15:0] req_position = '0;
   logic [31:0] req_current_bytes = '0;
   logic [31:0] req_previous_bytes = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [15:0] rsp_echo_position;
   logic        rsp_still_shown;
   logic [16:0] rsp_survivor_count;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // mirror of the block's registers and survivor state
   cfg_type     scan_cfg;
   bit          survivor_map [REGION_BYTES];
   logic [16:0] survivor_total = '0;

   rsp_type        scan_results_due [$];
   script_row_type scan_script [$];

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          beats_in_flight = 0;

   memory_value_scan_filter #(
      .REGION_BYTES(REGION_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_current_bytes  (req_current_bytes),
      .req_previous_bytes (req_previous_bytes),
      .empty              (empty),
      .pop                (pop),
      .rsp_echo_position  (rsp_echo_position),
      .rsp_still_shown    (rsp_still_shown),
      .rsp_survivor_count (rsp_survivor_count),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build a value of n bytes, sign-extended in signed mode
   function automatic logic [31:0] assemble(logic [31:0] bytes, int unsigned n);
      logic [31:0] v;
      logic [7:0]  b;
      int          i;
      v = '0;
      for (i = 0; i < n; i++) begin
         b = bytes[8*i +: 8];
         if (scan_cfg.big_endian) v = {v[23:0], b};
         else v[8*i +: 8] = b;
      end
      if (scan_cfg.signed_compare && v[8*n-1]) begin
         for (i = n; i < 4; i++) v[8*i +: 8] = 8'hFF;
      end
      return v;
   endfunction

   // Update the survivor state for one beat and return its result
   function automatic rsp_type apply_scan_beat(scan_beat_type beat);
      rsp_type            r;
      int unsigned        len;
      int unsigned        n;
      int unsigned        p;
      logic [31:0]        lhs;
      logic [31:0]        rhs;
      logic signed [32:0] a;
      logic signed [32:0] b;
      bit                 keep;
      if (beat.kind == KIND_RESTART) begin
         len = (scan_cfg.region_length > REGION_BYTES) ? REGION_BYTES
                                                       : scan_cfg.region_length;
         for (p = 0; p < REGION_BYTES; p++) survivor_map[p] = (p < len);
         survivor_total = len[16:0];
         r.echo_position  = '0;
         r.still_shown    = survivor_map[0];
         r.survivor_count = survivor_total;
         return r;
      end
      if (beat.position < REGION_BYTES && survivor_map[beat.position]) begin
         if (scan_cfg.data_size == 0) n = 1;
         else if (scan_cfg.data_size > 4) n = 4;
         else n = scan_cfg.data_size;
         lhs = assemble(beat.current_bytes, n);
         rhs = scan_cfg.compare_to_previous ? assemble(beat.previous_bytes, n)
                                            : scan_cfg.compare_value;
         // widen by one bit so a single signed compare covers both modes
         a = scan_cfg.signed_compare ? {lhs[31], lhs} : {1'b0, lhs};
         b = scan_cfg.signed_compare ? {rhs[31], rhs} : {1'b0, rhs};
         case (scan_cfg.compare_func)
            FUNC_LT: keep = (a < b);
            FUNC_GT: keep = (a > b);
            FUNC_LE: keep = (a <= b);
            FUNC_GE: keep = (a >= b);
            FUNC_EQ: keep = (a == b);
            FUNC_NE: keep = (a != b);
            default: keep = 1'b1;
         endcase
         if (!keep) begin
            survivor_map[beat.position] = 1'b0;
            if (survivor_total != 0) survivor_total = survivor_total - 1'b1;
         end
      end
      r.echo_position  = beat.position;
      r.still_shown    = (beat.position < REGION_BYTES) ? survivor_map[beat.position] : 1'b0;
      r.survivor_count = survivor_total;
      return r;
   endfunction

   // Bytes weighted toward sign and range boundaries
   function automatic logic [31:0] mixed_bytes();
      logic [31:0] v;
      int          i;
      if ($urandom_range(2) == 0) return $urandom;
      for (i = 0; i < 4; i++) begin
         case ($urandom_range(5))
            0:       v[8*i +: 8] = 8'h00;
            1:       v[8*i +: 8] = 8'h01;
            2:       v[8*i +: 8] = 8'h7F;
            3:       v[8*i +: 8] = 8'h80;
            4:       v[8*i +: 8] = 8'hFF;
            default: v[8*i +: 8] = 8'($urandom);
         endcase
      end
      return v;
   endfunction

   // Test beat aimed mostly at the live part of the region
   function automatic scan_beat_type random_test_beat();
      scan_beat_type b;
      int unsigned   span;
      span = (scan_cfg.region_length > REGION_BYTES) ? REGION_BYTES
                                                     : scan_cfg.region_length;
      span = span + 2;
      if (span > 65535) span = 65535;
      b.kind = KIND_TEST;
      case ($urandom_range(9))
         0, 1:       b.position = 16'($urandom);
         2, 3, 4, 5: b.position = 16'($urandom_range(0, (span < 63) ? span : 63));
         default:    b.position = 16'($urandom_range(0, span));
      endcase
      b.current_bytes = mixed_bytes();
      case ($urandom_range(2))
         0:       b.previous_bytes = b.current_bytes;
         1:       b.previous_bytes = mixed_bytes();
         default: b.previous_bytes = b.current_bytes ^ (32'h1 << $urandom_range(31));
      endcase
      return b;
   endfunction

   function automatic logic [31:0] pick_reg_value(logic [2:0] idx, int flavor);
      logic [31:0] v;
      logic [31:0] field_mask;
      case (idx)
         CSR_DATA_SIZE: begin
            v = $urandom_range(7);
            field_mask = 32'h7;
         end
         CSR_COMPARE_FUNC: begin
            v = ($urandom_range(9) == 0) ? $urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)
                                         : $urandom_range(FUNC_LT, FUNC_NE);
            field_mask = 32'h7;
         end
         CSR_COMPARE_VALUE: begin
            case ($urandom_range(11))
               0:       v = 32'h0000_0000;
               1:       v = 32'h0000_0001;
               2:       v = 32'h0000_007F;
               3:       v = 32'h0000_0080;
               4:       v = 32'h0000_00FF;
               5:       v = 32'h0000_7FFF;
               6:       v = 32'h0000_8000;
               7:       v = 32'h7FFF_FFFF;
               8:       v = 32'h8000_0000;
               9:       v = 32'hFFFF_FFFF;
               10:      v = $urandom_range(3);
               default: v = $urandom;
            endcase
            field_mask = 32'hFFFF_FFFF;
         end
         CSR_REGION_LENGTH: begin
            case ($urandom_range(9))
               0:       v = 0;
               1:       v = 1;
               2:       v = 32;
               3:       v = 33;
               4:       v = REGION_BYTES;
               5:       v = $urandom_range(REGION_BYTES + 1, 32'h1FFFF);
               default: v = $urandom_range(2, 96);
            endcase
            field_mask = 32'h1FFFF;
         end
         default: begin
            v = $urandom_range(1);
            field_mask = 32'h1;
         end
      endcase
      // unused upper bits of the write word must be dropped
      if ($urandom_range(7) == 0) v = v | ($urandom & ~field_mask);
      if (flavor == FLAVOR_ALL_ONES) v = 32'hFFFF_FFFF;
      else if (flavor == FLAVOR_ALL_ZEROS) v = 32'h0;
      return v;
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [31:0] value);
      script_row_type row;
      row.op        = ROW_WRITE;
      row.reg_index = idx;
      row.reg_value = value;
      row.beat      = '0;
      row.typed     = 1'b0;
      row.want      = '0;
      scan_script.push_back(row);
   endfunction

   function automatic void add_beat(logic kind, logic [15:0] pos, logic [31:0] cur,
                                    logic [31:0] prev, bit typed, logic [15:0] echo,
                                    logic shown, logic [16:0] count);
      script_row_type row;
      row.op        = ROW_BEAT;
      row.reg_index = '0;
      row.reg_value = '0;
      row.beat      = {kind, pos, cur, prev};
      row.typed     = typed;
      row.want      = {echo, shown, count};
      scan_script.push_back(row);
   endfunction

   // Directed beats; typed rows carry results that follow straight from the rules
   function automatic void build_script();
      add_beat(KIND_TEST, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 0, 17'd0);
      add_beat(KIND_RESTART, 16'h1234, $urandom, $urandom, 1, 16'h0000, 1, 17'd65536);
      add_beat(KIND_TEST, 16'hFFFF, 32'hFFFF_FF00, 32'h0, 1, 16'hFFFF, 1, 17'd65536);
      add_beat(KIND_TEST, 16'hFFFF, 32'h0000_0001, 32'h0, 1, 16'hFFFF, 0, 17'd65535);
      add_beat(KIND_TEST, 16'hFFFF, 32'h0, 32'h0, 1, 16'hFFFF, 0, 17'd65535);
      // empty region, then a length beyond the store
      add_write(CSR_REGION_LENGTH, 32'h0);
      add_beat(KIND_RESTART, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 0, 17'd0);
      add_beat(KIND_TEST, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 0, 17'd0);
      add_write(CSR_REGION_LENGTH, 32'h1FFFF);
      add_beat(KIND_RESTART, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 1, 17'd65536);
      add_write(CSR_REGION_LENGTH, 32'h1);
      add_beat(KIND_RESTART, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 1, 17'd1);
      add_beat(KIND_TEST, 16'h0001, 32'h0, 32'h0, 1, 16'h0001, 0, 17'd1);
      // spare relation codes keep every survivor
      add_write(CSR_COMPARE_FUNC, FUNC_SPARE_LO);
      add_beat(KIND_TEST, 16'h0000, 32'h0000_00FF, 32'h0, 1, 16'h0000, 1, 17'd1);
      add_write(CSR_COMPARE_FUNC, FUNC_SPARE_HI);
      add_beat(KIND_TEST, 16'h0000, 32'h0000_005A, 32'h0, 1, 16'h0000, 1, 17'd1);
      add_write(CSR_REGION_LENGTH, 32'd40);
      add_beat(KIND_RESTART, 16'h0000, 32'h0, 32'h0, 1, 16'h0000, 1, 17'd40);
      // signed byte with size zero acting as one
      add_write(CSR_COMPARE_FUNC, FUNC_LT);
      add_write(CSR_SIGNED_COMPARE, 32'h1);
      add_write(CSR_DATA_SIZE, 32'h0);
      add_write(CSR_COMPARE_VALUE, 32'h0);
      add_beat(KIND_TEST, 16'd2, 32'h0000_0080, 32'h0, 0, '0, 0, '0);
      add_beat(KIND_TEST, 16'd3, 32'h0000_007F, 32'h0, 0, '0, 0, '0);
      // oversized data size acting as four, big-endian
      add_write(CSR_DATA_SIZE, 32'd5);
      add_write(CSR_BIG_ENDIAN, 32'h1);
      add_write(CSR_COMPARE_FUNC, FUNC_GT);
      add_write(CSR_COMPARE_VALUE, 32'h7FFF_FFFE);
      add_beat(KIND_TEST, 16'd4, 32'hFFFF_FF7F, 32'h0, 0, '0, 0, '0);
      add_beat(KIND_TEST, 16'd5, 32'h0000_0080, 32'h0, 0, '0, 0, '0);
      // snapshot operand
      add_write(CSR_DATA_SIZE, 32'd2);
      add_write(CSR_COMPARE_PREV, 32'h1);
      add_write(CSR_COMPARE_FUNC, FUNC_LE);
      add_write(CSR_SIGNED_COMPARE, 32'h0);
      add_write(CSR_BIG_ENDIAN, 32'h0);
      add_beat(KIND_TEST, 16'd6, 32'h0000_1234, 32'h0000_1234, 0, '0, 0, '0);
      add_beat(KIND_TEST, 16'd7, 32'h0000_8000, 32'h0000_7FFF, 0, '0, 0, '0);
      add_write(CSR_DATA_SIZE, 32'd3);
      add_write(CSR_COMPARE_FUNC, FUNC_GE);
      add_write(CSR_SIGNED_COMPARE, 32'h1);
      add_beat(KIND_TEST, 16'd8, 32'h0080_0000, 32'h007F_FFFF, 0, '0, 0, '0);
      add_beat(KIND_TEST, 16'd9, 32'h007F_FFFF, 32'h00FF_FFFF, 0, '0, 0, '0);
      add_write(CSR_COMPARE_FUNC, FUNC_NE);
      add_write(CSR_DATA_SIZE, 32'd7);
      add_beat(KIND_TEST, 16'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0, 0, '0);
      add_beat(KIND_TEST, 16'd11, 32'h0, 32'hFFFF_FFFF, 0, '0, 0, '0);
      // four-byte big-endian match on the constant
      add_write(CSR_COMPARE_FUNC, FUNC_EQ);
      add_write(CSR_COMPARE_PREV, 32'h0);
      add_write(CSR_COMPARE_VALUE, 32'hDEAD_BEEF);
      add_write(CSR_BIG_ENDIAN, 32'h1);
      add_write(CSR_DATA_SIZE, 32'd4);
      add_beat(KIND_TEST, 16'd12, 32'hEFBE_ADDE, 32'h0, 0, '0, 0, '0);
   endfunction

   // Write one register; the enable drops with the next beat
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_DATA_SIZE:      scan_cfg.data_size = value[2:0];
         CSR_SIGNED_COMPARE: scan_cfg.signed_compare = value[0];
         CSR_COMPARE_FUNC:   scan_cfg.compare_func = value[2:0];
         CSR_COMPARE_PREV:   scan_cfg.compare_to_previous = value[0];
         CSR_COMPARE_VALUE:  scan_cfg.compare_value = value;
         CSR_BIG_ENDIAN:     scan_cfg.big_endian = value[0];
         CSR_REGION_LENGTH:  scan_cfg.region_length = value[16:0];
         default: ;
      endcase
   endtask

   // Offer one beat until taken, then record its expected result
   task automatic send_beat(input scan_beat_type beat, input bit typed, input rsp_type want);
      rsp_type predicted;
      csr_wen <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push               <= 1'b1;
      req_kind           <= beat.kind;
      req_position       <= beat.position;
      req_current_bytes  <= beat.current_bytes;
      req_previous_bytes <= beat.previous_bytes;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = apply_scan_beat(beat);
      scan_results_due.push_back(typed ? want : predicted);
      beats_in_flight = 1'b1;
   endtask

   // Drain all results, then let a restart walk finish before touching registers
   task automatic wait_idle();
      if (beats_in_flight) begin
         push <= 1'b0;
         do @(posedge clock); while (scan_results_due.size() != 0);
         repeat (SETTLE_CYCLES) @(posedge clock);
         beats_in_flight = 1'b0;
      end
   endtask

   // Result side: check each popped beat and choose the next pop
   always @(posedge clock) begin : result_side
      rsp_type seen;
      rsp_type want;
      if (!reset && pop && !empty) begin
         seen = {rsp_echo_position, rsp_still_shown, rsp_survivor_count};
         if (scan_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: echo_position %0d still_shown %0d %s %0d",
                        seen.echo_position, seen.still_shown, "survivor_count",
                        seen.survivor_count);
         end else begin
            want = scan_results_due.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch (exp/got): echo_position %0d/%0d %s %0d/%0d %s %0d/%0d",
                           want.echo_position, seen.echo_position,
                           "still_shown", want.still_shown, seen.still_shown,
                           "survivor_count", want.survivor_count, seen.survivor_count);
            end
         end
      end
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, scan_results_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      scan_beat_type beat;
      int            phase;
      int            flavor;
      int            sent_in_phase;
      int            burst;
      bit            paused;
      scan_cfg = '0;
      scan_cfg.data_size     = RST_DATA_SIZE;
      scan_cfg.compare_func  = RST_COMPARE_FUNC;
      scan_cfg.region_length = RST_REGION_LENGTH;
      build_script();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (scan_script[r]) begin
         if (scan_script[r].op == ROW_WRITE) begin
            wait_idle();
            write_reg(scan_script[r].reg_index, scan_script[r].reg_value);
         end else begin
            send_beat(scan_script[r].beat, scan_script[r].typed, scan_script[r].want);
         end
      end

      // random part: restart followed by a burst of tests, with some noise
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         if (phase == 0) flavor = FLAVOR_ALL_ONES;
         else if (phase == 1) flavor = FLAVOR_ALL_ZEROS;
         else flavor = FLAVOR_RANDOM;
         write_reg(CSR_DATA_SIZE, pick_reg_value(CSR_DATA_SIZE, flavor));
         write_reg(CSR_SIGNED_COMPARE, pick_reg_value(CSR_SIGNED_COMPARE, flavor));
         write_reg(CSR_COMPARE_FUNC, pick_reg_value(CSR_COMPARE_FUNC, flavor));
         write_reg(CSR_COMPARE_PREV, pick_reg_value(CSR_COMPARE_PREV, flavor));
         write_reg(CSR_COMPARE_VALUE, pick_reg_value(CSR_COMPARE_VALUE, flavor));
         write_reg(CSR_BIG_ENDIAN, pick_reg_value(CSR_BIG_ENDIAN, flavor));
         write_reg(CSR_REGION_LENGTH, pick_reg_value(CSR_REGION_LENGTH, flavor));

         // hold the result side off past a restart walk so the block backs up
         if (phase % 8 == 0) hold_request = HOLD_OFF_CYCLES;

         sent_in_phase = 0;
         paused = 1'b0;
         while (sent_in_phase < BEATS_PER_PHASE) begin
            if ($urandom_range(9) == 0) begin
               beat = {1'($urandom_range(1)), 16'($urandom), 32'($urandom), 32'($urandom)};
               send_beat(beat, 1'b0, '0);
               sent_in_phase++;
            end else begin
               beat = random_test_beat();
               beat.kind = KIND_RESTART;
               send_beat(beat, 1'b0, '0);
               sent_in_phase++;
               burst = $urandom_range(4, 24);
               repeat (burst) begin
                  send_beat(random_test_beat(), 1'b0, '0);
                  sent_in_phase++;
               end
            end
            // pause the sender until every result is back
            if (phase % 4 == 2 && !paused && sent_in_phase >= BEATS_PER_PHASE / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mvsf_pkg.sv
rtl/core/mvsf_queue.sv
rtl/core/mvsf_front.sv
rtl/core/mvsf_back.sv
rtl/core/memory_value_scan_filter.sv
test/memory_value_scan_filter_tb.sv
